// File: rtl/asc_pkg.sv
// Package for the accelerometer step counter: types, widths, filter coefficients.
// Used by all modules but asc_checker; depends on nothing.
package asc_pkg;
  localparam int HpBits  = 34;
  localparam int DotBits = 38;
  localparam int LpBits  = 56;
  localparam int QBits   = 16;
  localparam int CfgBits = 39;
  localparam int DetBits = 40;
  localparam int UserBits = 18;

  localparam logic signed [31:0] HpA1 = -32'sd2052132225;
  localparam logic signed [31:0] HpA2 = 32'sd982447822;
  localparam logic signed [31:0] HpB0 = 32'sd1027080468;
  localparam logic signed [31:0] HpB1 = -32'sd2054160936;
  localparam logic signed [31:0] LpA1 = -32'sd1676130396;
  localparam logic signed [31:0] LpA2 = 32'sd688645970;
  localparam logic signed [31:0] LpB0 = 32'sd21564350;
  localparam logic signed [31:0] LpB1 = 32'sd43128699;

  localparam logic [0:0] RegStepRange = 1'b0;
  localparam logic [0:0] RegSlope     = 1'b1;

  // Coefficient rounded from Q2.30 to the chosen fraction width, half away from zero.
  function automatic logic signed [31:0] coef_round(logic signed [31:0] c30, int frac);
    logic signed [32:0] mag;
    int sh;
    sh = 30 - frac;
    if (sh <= 0) begin
      return c30;
    end
    mag = (c30 < 0) ? -33'(c30) : 33'(c30);
    mag = (mag + (33'sd1 <<< (sh - 1))) >>> sh;
    return (c30 < 0) ? -32'(mag) : 32'(mag);
  endfunction

  typedef struct packed {
    logic signed [UserBits-1:0] user_x;
    logic signed [UserBits-1:0] user_y;
    logic signed [UserBits-1:0] user_z;
    logic signed [DotBits-1:0]  dot;
  } front_item_t;
endpackage

// File: rtl/asc_if.sv
// Valid-ready channel interface with source and sink modports.
// Payload type is given as a parameter; depends on nothing else.
interface asc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/asc_cfg_if.sv
// Configuration write channel: register index and data with valid and ready.
// Depends on nothing.
interface asc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/asc_mac.sv
// Shared multiply-accumulate step: floor(coef * value / 2^frac), value up to 56 bits.
// The value is split into a high and a low part; each product is 32 by 32 or less,
// registered, then summed. Uses asc_pkg.
module asc_mac import asc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic signed [31:0] coef,
  input  logic signed [LpBits-1:0] value,
  output logic signed [63:0] term
);
  logic signed [LpBits-1:0] hi;
  logic [COEF_FRAC_BITS-1:0] lo;
  logic signed [63:0] prod_hi;
  logic signed [63:0] prod_lo;

  assign hi = value >>> COEF_FRAC_BITS;
  assign lo = value[COEF_FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    prod_hi <= 64'(coef) * 64'(hi);
    prod_lo <= 64'(coef) * $signed({1'b0, lo});
  end

  assign term = prod_hi + (prod_lo >>> COEF_FRAC_BITS);
endmodule

// File: rtl/asc_front.sv
// Front part: takes samples, runs the three high-pass biquads on a shared multiplier,
// forms the dot product and pushes one front item per sample. Uses asc_pkg, asc_mac.
module asc_front import asc_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [SAMPLE_BITS-1:0] ax,
  input  logic [SAMPLE_BITS-1:0] ay,
  input  logic [SAMPLE_BITS-1:0] az,
  output logic        out_valid,
  input  logic        out_ready,
  output front_item_t out_item
);
  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DOT, S_PUSH} state_t;

  localparam logic signed [31:0] CB0 = coef_round(HpB0, COEF_FRAC_BITS);
  localparam logic signed [31:0] CB1 = coef_round(HpB1, COEF_FRAC_BITS);
  localparam logic signed [31:0] CA1 = coef_round(HpA1, COEF_FRAC_BITS);
  localparam logic signed [31:0] CA2 = coef_round(HpA2, COEF_FRAC_BITS);
  localparam logic signed [63:0] HpMax = (64'sd1 <<< (HpBits - 1)) - 1;
  localparam logic signed [63:0] HpMin = -(64'sd1 <<< (HpBits - 1));
  localparam logic signed [63:0] DotMax = (64'sd1 <<< (DotBits - 1)) - 1;
  localparam logic signed [63:0] DotMin = -(64'sd1 <<< (DotBits - 1));

  state_t state;
  logic signed [SAMPLE_BITS-1:0] x0 [3];
  logic signed [SAMPLE_BITS-1:0] raw1 [3];
  logic signed [SAMPLE_BITS-1:0] raw2 [3];
  logic signed [HpBits-1:0] hp1 [3];
  logic signed [HpBits-1:0] hp2 [3];
  logic signed [UserBits-1:0] user [3];
  logic [1:0] axis;
  logic [2:0] tap;
  logic [1:0] wait_cnt;
  logic signed [63:0] acc;
  logic signed [63:0] dot_acc;
  logic signed [31:0] mac_coef;
  logic signed [LpBits-1:0] mac_val;
  logic signed [63:0] mac_term;
  logic signed [63:0] sum;
  logic signed [HpBits-1:0] y;
  logic signed [UserBits-1:0] u;
  logic signed [63:0] dprod;

  asc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk(clk), .coef(mac_coef), .value(mac_val), .term(mac_term)
  );

  always_comb begin
    mac_coef = CB0;
    mac_val  = '0;
    unique case (tap)
      3'd0: begin mac_coef = CB0; mac_val = LpBits'(x0[axis]) <<< QBits; end
      3'd1: begin mac_coef = CB1; mac_val = LpBits'(raw1[axis]) <<< QBits; end
      3'd2: begin mac_coef = CB0; mac_val = LpBits'(raw2[axis]) <<< QBits; end
      3'd3: begin mac_coef = CA1; mac_val = LpBits'(hp1[axis]); end
      3'd4: begin mac_coef = CA2; mac_val = LpBits'(hp2[axis]); end
      default: begin mac_coef = CB0; mac_val = '0; end
    endcase
  end

  always_comb begin
    sum = (tap >= 3'd3) ? acc - mac_term : acc + mac_term;
    if (sum > HpMax) y = HpMax[HpBits-1:0];
    else if (sum < HpMin) y = HpMin[HpBits-1:0];
    else y = sum[HpBits-1:0];
    u = UserBits'(y >>> QBits);
    dprod = 64'(u) * 64'(36'(x0[axis]) - 36'(u));
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      tap <= '0;
      wait_cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        raw1[i] <= '0; raw2[i] <= '0; hp1[i] <= '0; hp2[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x0[0] <= ax; x0[1] <= ay; x0[2] <= az;
            axis <= '0; tap <= '0; wait_cnt <= '0;
            acc <= '0; dot_acc <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (wait_cnt == 2'd0) begin
            wait_cnt <= 2'd1;
          end else begin
            wait_cnt <= 2'd0;
            if (tap == 3'd4) begin
              hp2[axis] <= hp1[axis]; hp1[axis] <= y;
              raw2[axis] <= raw1[axis]; raw1[axis] <= x0[axis];
              user[axis] <= u;
              dot_acc <= dot_acc + dprod;
              acc <= '0; tap <= '0;
              if (axis == 2'd2) state <= S_DOT;
              else axis <= axis + 2'd1;
            end else begin
              acc <= sum;
              tap <= tap + 3'd1;
            end
          end
        end
        S_DOT: begin
          out_item.user_x <= user[0];
          out_item.user_y <= user[1];
          out_item.user_z <= user[2];
          if (dot_acc > DotMax) out_item.dot <= DotMax[DotBits-1:0];
          else if (dot_acc < DotMin) out_item.dot <= DotMin[DotBits-1:0];
          else out_item.dot <= dot_acc[DotBits-1:0];
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/asc_queue.sv
// Two-entry queue between the front and back parts. Uses asc_pkg.
module asc_queue import asc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  front_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output front_item_t out_item
);
  front_item_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wr_ptr] <= in_item;
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= '0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule

// File: rtl/asc_back.sv
// Back part: low-pass biquad on the dot product, peak and valley detection and
// the step count, with an output register. Uses asc_pkg, asc_mac.
module asc_back import asc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  input  logic [CfgBits-1:0] range_thr,
  input  logic [CfgBits-1:0] slope_thr,
  input  logic in_valid,
  output logic in_ready,
  input  front_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [UserBits-1:0] user_x,
  output logic signed [UserBits-1:0] user_y,
  output logic signed [UserBits-1:0] user_z,
  output logic signed [DetBits-1:0]  dot_filtered,
  output logic [31:0] step_total,
  output logic        step_counted
);
  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DET, S_OUT} state_t;

  localparam logic signed [31:0] CB0 = coef_round(LpB0, COEF_FRAC_BITS);
  localparam logic signed [31:0] CB1 = coef_round(LpB1, COEF_FRAC_BITS);
  localparam logic signed [31:0] CA1 = coef_round(LpA1, COEF_FRAC_BITS);
  localparam logic signed [31:0] CA2 = coef_round(LpA2, COEF_FRAC_BITS);
  localparam logic signed [63:0] LpMax = (64'sd1 <<< (LpBits - 1)) - 1;
  localparam logic signed [63:0] LpMin = -(64'sd1 <<< (LpBits - 1));

  state_t state;
  front_item_t item;
  logic signed [DotBits-1:0] dh1, dh2;
  logic signed [LpBits-1:0] lh1, lh2, z;
  logic signed [DetBits-1:0] w1, w2, peak, valley, d0;
  logic [3:0] flags;
  logic [31:0] count;
  logic [2:0] tap;
  logic wait_cnt;
  logic signed [63:0] acc, sum;
  logic signed [31:0] mac_coef;
  logic signed [LpBits-1:0] mac_val;
  logic signed [63:0] mac_term;
  logic signed [DetBits:0] slope_s, range_s;
  logic is_peak, is_valley, counted;
  logic signed [DetBits-1:0] peak_n, valley_n;
  logic [3:0] flags_n;

  asc_mac #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk(clk), .coef(mac_coef), .value(mac_val), .term(mac_term)
  );

  always_comb begin
    mac_coef = CB0;
    mac_val  = '0;
    unique case (tap)
      3'd0: begin mac_coef = CB0; mac_val = LpBits'(item.dot) <<< QBits; end
      3'd1: begin mac_coef = CB1; mac_val = LpBits'(dh1) <<< QBits; end
      3'd2: begin mac_coef = CB0; mac_val = LpBits'(dh2) <<< QBits; end
      3'd3: begin mac_coef = CA1; mac_val = lh1; end
      3'd4: begin mac_coef = CA2; mac_val = lh2; end
      default: begin mac_coef = CB0; mac_val = '0; end
    endcase
    sum = (tap >= 3'd3) ? acc - mac_term : acc + mac_term;
    if (sum > LpMax) z = LpMax[LpBits-1:0];
    else if (sum < LpMin) z = LpMin[LpBits-1:0];
    else z = sum[LpBits-1:0];
  end

  always_comb begin
    slope_s = $signed({2'b00, slope_thr});
    range_s = $signed({2'b00, range_thr});
    is_peak = (w2 < w1) && (d0 < w1) && (($signed(41'(w1)) - 41'(valley)) > slope_s);
    is_valley = !is_peak && (w2 > w1) && (d0 > w1)
                && (($signed(41'(peak)) - 41'(w1)) > slope_s);
    peak_n = peak; valley_n = valley; flags_n = flags; counted = 1'b0;
    if (is_peak) begin
      peak_n = w1;
      flags_n[1] = 1'b0;
      if (w1 != 0 && valley != 0 && !flags[0]
          && ($signed(41'(w1)) - 41'(valley)) > range_s) begin
        if (flags[3]) flags_n[3] = 1'b0;
        else begin counted = 1'b1; flags_n[0] = 1'b1; flags_n[2] = 1'b1; end
      end
    end else if (is_valley) begin
      valley_n = w1;
      flags_n[0] = 1'b0;
      if (peak != 0 && w1 != 0 && !flags[1]
          && ($signed(41'(peak)) - 41'(w1)) > range_s) begin
        if (flags[2]) flags_n[2] = 1'b0;
        else begin counted = 1'b1; flags_n[1] = 1'b1; flags_n[3] = 1'b1; end
      end
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dh1 <= '0; dh2 <= '0; lh1 <= '0; lh2 <= '0;
      w1 <= '0; w2 <= '0; peak <= '0; valley <= '0;
      flags <= '0; count <= '0; tap <= '0; wait_cnt <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item; acc <= '0; tap <= '0; wait_cnt <= 1'b0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (!wait_cnt) begin
            wait_cnt <= 1'b1;
          end else begin
            wait_cnt <= 1'b0;
            if (tap == 3'd4) begin
              lh2 <= lh1; lh1 <= z;
              dh2 <= dh1; dh1 <= item.dot;
              d0 <= DetBits'(z >>> QBits);
              state <= S_DET;
            end else begin
              acc <= sum; tap <= tap + 3'd1;
            end
          end
        end
        S_DET: begin
          peak <= peak_n; valley <= valley_n; flags <= flags_n;
          if (counted && count != 32'hFFFF_FFFF) count <= count + 32'd1;
          step_total <= (counted && count != 32'hFFFF_FFFF) ? count + 32'd1 : count;
          step_counted <= counted;
          w2 <= w1; w1 <= d0;
          user_x <= item.user_x; user_y <= item.user_y; user_z <= item.user_z;
          dot_filtered <= d0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/accel_step_counter_top.sv
// Top level of the accelerometer step counter.
// Instantiates asc_front, asc_queue and asc_back; uses asc_pkg and the channel interfaces.
//
// Channels: sample_in carries accel_x/y/z; result_out carries user_x/y/z,
// dot_filtered, step_total and step_counted; cfg writes register 0
// (step range threshold) or 1 (slope threshold); other indexes are ignored.
// Every sample gives exactly one result.
// From sample transfer to result valid, the front
// runs fifteen multiply-accumulate steps on its one shared
// multiplier, the back runs five for the low-pass filter and one detect state.
// The front takes a new sample only after its item for the last one is pushed.
// A two-entry queue lets the front take a new sample while the back works or
// its result waits; a stalled receiver holds the result steady and the
// queue then fills and stops the front.
// Reset clears all filter histories, extremes, flags, the count and the threshold registers.
module accel_step_counter_top import asc_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  asc_cfg_if.sink cfg,
  input  logic sample_in_valid,
  output logic sample_in_ready,
  input  logic [SAMPLE_BITS-1:0] accel_x,
  input  logic [SAMPLE_BITS-1:0] accel_y,
  input  logic [SAMPLE_BITS-1:0] accel_z,
  output logic result_out_valid,
  input  logic result_out_ready,
  output logic signed [UserBits-1:0] user_x,
  output logic signed [UserBits-1:0] user_y,
  output logic signed [UserBits-1:0] user_z,
  output logic signed [DetBits-1:0]  dot_filtered,
  output logic [31:0] step_total,
  output logic        step_counted
);
  logic [CfgBits-1:0] range_thr, slope_thr;
  asc_if #(.payload_t(front_item_t)) f2q ();
  asc_if #(.payload_t(front_item_t)) q2b ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_thr <= '0;
      slope_thr <= '0;
    end else if (cfg.valid && cfg.index[7:1] == '0) begin
      if (cfg.index[0] == RegStepRange) range_thr <= cfg.data[CfgBits-1:0];
      else slope_thr <= cfg.data[CfgBits-1:0];
    end
  end

  asc_front #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(sample_in_valid), .in_ready(sample_in_ready),
    .ax(accel_x), .ay(accel_y), .az(accel_z),
    .out_valid(f2q.valid), .out_ready(f2q.ready), .out_item(f2q.data)
  );

  asc_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f2q.valid), .in_ready(f2q.ready), .in_item(f2q.data),
    .out_valid(q2b.valid), .out_ready(q2b.ready), .out_item(q2b.data)
  );

  asc_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .range_thr(range_thr), .slope_thr(slope_thr),
    .in_valid(q2b.valid), .in_ready(q2b.ready), .in_item(q2b.data),
    .out_valid(result_out_valid), .out_ready(result_out_ready),
    .user_x(user_x), .user_y(user_y), .user_z(user_z),
    .dot_filtered(dot_filtered), .step_total(step_total), .step_counted(step_counted)
  );
endmodule

// File: rtl/asc_checker.sv
// Port-level checker for the step counter, bound to the top level.
// Depends on accel_step_counter_top's ports only.
module asc_checker (
  input logic clk,
  input logic rst,
  input logic result_out_valid,
  input logic result_out_ready,
  input logic [31:0] step_total,
  input logic step_counted
);
  logic out_fire;
  assign out_fire = result_out_valid && result_out_ready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_out_valid && !result_out_ready |=> result_out_valid && $stable(step_total))
    else $error("result dropped while stalled");
  a_no_step_zero: assert property (@(posedge clk) disable iff (rst)
    result_out_valid && step_counted |-> step_total != 32'd0)
    else $error("step flagged with zero total");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_out_valid)
    else $error("result valid after reset");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> !result_out_valid)
    else $error("back-to-back results");
endmodule

bind accel_step_counter_top asc_checker u_asc_checker (
  .clk(clk), .rst(rst),
  .result_out_valid(result_out_valid), .result_out_ready(result_out_ready),
  .step_total(step_total), .step_counted(step_counted)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for accel_step_counter_top: directed and random samples are
// predicted by an independent fixed-point model and every result is compared field by field.
// Depends on asc_pkg, asc_if and asc_cfg_if.
module testbench;
  import asc_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } sample_t;

  typedef struct packed {
    logic [UserBits-1:0] user_x;
    logic [UserBits-1:0] user_y;
    logic [UserBits-1:0] user_z;
    logic [DetBits-1:0]  dot;
    logic [31:0]         total;
    logic                counted;
  } result_t;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 400;
  localparam logic [7:0] RegUnknown = 8'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  asc_if #(.payload_t(sample_t)) smp ();
  asc_if #(.payload_t(result_t)) res ();
  asc_cfg_if cfg ();

  accel_step_counter_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .sample_in_valid  (smp.valid),
    .sample_in_ready  (smp.ready),
    .accel_x          (smp.data.x),
    .accel_y          (smp.data.y),
    .accel_z          (smp.data.z),
    .result_out_valid (res.valid),
    .result_out_ready (res.ready),
    .user_x           (res.data.user_x),
    .user_y           (res.data.user_y),
    .user_z           (res.data.user_z),
    .dot_filtered     (res.data.dot),
    .step_total       (res.data.total),
    .step_counted     (res.data.counted)
  );

  always #1 clk = ~clk;

  // Predictor state.
  longint range_thr, slope_thr;
  longint raw_hist[6];
  longint hp_hist[6];
  longint dot_hist[2];
  longint lp_hist[2];
  longint window[2];
  longint peak, valley;
  logic [3:0] flags;
  logic [31:0] steps;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int stall_left = 0;

  initial begin
    smp.valid = 1'b0;
    smp.data = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  function automatic longint clip(longint v, int bits);
    longint lim;
    lim = longint'(1) <<< (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mul_q30(longint c, longint v);
    longint hi, lo;
    hi = v >>> 30;
    lo = v - (hi <<< 30);
    return c * hi + ((c * lo) >>> 30);
  endfunction

  function automatic longint biquad(longint b0, longint b1, longint a1, longint a2,
                                    longint x0, longint x1, longint x2,
                                    longint y1, longint y2, int bits);
    longint acc;
    acc = mul_q30(b0, x0 <<< QBits) + mul_q30(b1, x1 <<< QBits) + mul_q30(b0, x2 <<< QBits)
        - mul_q30(a1, y1) - mul_q30(a2, y2);
    return clip(acc, bits);
  endfunction

  function automatic void reset_model();
    range_thr = 0;
    slope_thr = 0;
    for (int i = 0; i < 6; i++) begin
      raw_hist[i] = 0;
      hp_hist[i] = 0;
    end
    for (int i = 0; i < 2; i++) begin
      dot_hist[i] = 0;
      lp_hist[i] = 0;
      window[i] = 0;
    end
    peak = 0;
    valley = 0;
    flags = '0;
    steps = '0;
  endfunction

  function automatic result_t predict_step(sample_t s);
    result_t r;
    longint x0, y, dot, z, d0, d1, d2;
    longint user[3];
    logic [15:0] raw[3];
    bit counted;
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    dot = 0;
    counted = 1'b0;
    for (int a = 0; a < 3; a++) begin
      x0 = longint'($signed(raw[a]));
      y = biquad(longint'(HpB0), longint'(HpB1), longint'(HpA1), longint'(HpA2),
                 x0, raw_hist[2*a], raw_hist[2*a+1], hp_hist[2*a], hp_hist[2*a+1], HpBits);
      raw_hist[2*a+1] = raw_hist[2*a];
      raw_hist[2*a] = x0;
      hp_hist[2*a+1] = hp_hist[2*a];
      hp_hist[2*a] = y;
      user[a] = y >>> QBits;
      dot += user[a] * (x0 - user[a]);
    end
    dot = clip(dot, DotBits);
    z = biquad(longint'(LpB0), longint'(LpB1), longint'(LpA1), longint'(LpA2),
               dot, dot_hist[0], dot_hist[1], lp_hist[0], lp_hist[1], LpBits);
    dot_hist[1] = dot_hist[0];
    dot_hist[0] = dot;
    lp_hist[1] = lp_hist[0];
    lp_hist[0] = z;
    d0 = z >>> QBits;
    d1 = window[0];
    d2 = window[1];
    if (d2 < d1 && d0 < d1 && d1 - valley > slope_thr) begin
      peak = d1;
      flags[1] = 1'b0;
      if (peak != 0 && valley != 0 && !flags[0] && peak - valley > range_thr) begin
        if (flags[3]) begin
          flags[3] = 1'b0;
        end else begin
          counted = 1'b1;
          flags[0] = 1'b1;
          flags[2] = 1'b1;
        end
      end
    end else if (d2 > d1 && d0 > d1 && peak - d1 > slope_thr) begin
      valley = d1;
      flags[0] = 1'b0;
      if (peak != 0 && valley != 0 && !flags[1] && peak - valley > range_thr) begin
        if (flags[2]) begin
          flags[2] = 1'b0;
        end else begin
          counted = 1'b1;
          flags[1] = 1'b1;
          flags[3] = 1'b1;
        end
      end
    end
    if (counted && steps != 32'hFFFF_FFFF) steps++;
    window[1] = d1;
    window[0] = d0;
    r.user_x = user[0][UserBits-1:0];
    r.user_y = user[1][UserBits-1:0];
    r.user_z = user[2][UserBits-1:0];
    r.dot = d0[DetBits-1:0];
    r.total = steps;
    r.counted = counted;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    forever begin
      wait (long_hold_req);
      repeat (LongHold) @(posedge clk);
      long_hold_done = 1'b1;
      wait (!long_hold_req);
      long_hold_done = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (long_hold_req && !long_hold_done)) begin
      res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      res.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Both signals are stable at the falling edge, so a transfer seen here completes next edge.
  always @(negedge clk) begin
    result_t want;
    if (res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result, expected none, got %h", $time, res.data);
      end else begin
        want = pending_results.pop_front();
        if (res.data !== want) begin
          errors++;
          if (res.data.user_x !== want.user_x)
            $display("%0t user_x expected %0d got %0d", $time,
                     $signed(want.user_x), $signed(res.data.user_x));
          if (res.data.user_y !== want.user_y)
            $display("%0t user_y expected %0d got %0d", $time,
                     $signed(want.user_y), $signed(res.data.user_y));
          if (res.data.user_z !== want.user_z)
            $display("%0t user_z expected %0d got %0d", $time,
                     $signed(want.user_z), $signed(res.data.user_z));
          if (res.data.dot !== want.dot)
            $display("%0t dot_filtered expected %0d got %0d", $time,
                     $signed(want.dot), $signed(res.data.dot));
          if (res.data.total !== want.total)
            $display("%0t step_total expected %0d got %0d", $time,
                     want.total, res.data.total);
          if (res.data.counted !== want.counted)
            $display("%0t step_counted expected %0d got %0d", $time,
                     want.counted, res.data.counted);
        end
      end
    end
  end

  task automatic send_sample(int x, int y, int z);
    sample_t s;
    bit taken;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.data <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = smp.ready;
      @(posedge clk);
    end
    pending_results.push_back(predict_step(s));
  endtask

  task automatic stop_sending();
    smp.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] index, logic [63:0] value);
    bit taken;
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg.ready;
      @(posedge clk);
    end
    cfg.valid <= 1'b0;
    if (index == 8'(RegStepRange)) range_thr = longint'(value[CfgBits-1:0]);
    else if (index == 8'(RegSlope)) slope_thr = longint'(value[CfgBits-1:0]);
  endtask

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // A periodic swing on a gravity offset, as seen while walking, with a little noise.
  task automatic send_walk(int n);
    int period, amp, gx, gy, gz, t, tri_pos, w;
    period = $urandom_range(8, 40);
    amp = $urandom_range(500, 16000);
    gx = $urandom_range(0, 8000) - 4000;
    gy = $urandom_range(0, 8000) - 4000;
    gz = $urandom_range(8000, 16000);
    for (int i = 0; i < n; i++) begin
      t = i % period;
      tri_pos = (2 * t < period) ? t : period - t;
      w = amp * (4 * tri_pos - period) / period;
      send_sample(clamp16(gx + w / 3 + $urandom_range(0, 200) - 100),
                  clamp16(gy - w / 4 + $urandom_range(0, 200) - 100),
                  clamp16(gz + w + $urandom_range(0, 200) - 100));
    end
  endtask

  task automatic test_extremes();
    int v[6] = '{32767, -32768, 0, -1, 1, 21845};
    write_reg(8'(RegStepRange), 64'd0);
    write_reg(8'(RegSlope), 64'd0);
    foreach (v[i]) send_sample(v[i], v[i], v[i]);
    for (int i = 0; i < 6; i++) send_sample(32767, -32768, 32767);
    for (int i = 0; i < 6; i++) send_sample(-32768, 32767, -32768);
    send_sample(16'h5555, 16'hAAAA, 16'h0F0F);
    send_sample(16'hAAAA, 16'h5555, 16'hF0F0);
    send_sample(0, 0, 0);
    // Writes with bits above the register width and to an index with no register.
    write_reg(8'(RegSlope), {25'h1FFFFFF, 39'd1000});
    write_reg(RegUnknown, 64'hFFFF_FFFF_FFFF_FFFF);
    send_walk(6);
  endtask

  task automatic test_walking(int rounds);
    for (int r = 0; r < rounds; r++) begin
      case ($urandom_range(0, 3))
        0: write_reg(8'(RegStepRange), 64'd0);
        1: write_reg(8'(RegStepRange), 64'($urandom_range(0, 50000000)));
        2: write_reg(8'(RegStepRange), 64'((longint'(1) <<< 39) - 1));
        default: write_reg(8'(RegStepRange), 64'($urandom_range(0, 5000000)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(8'(RegSlope), 64'd0);
        1: write_reg(8'(RegSlope), 64'((longint'(1) <<< 39) - 1));
        default: write_reg(8'(RegSlope), 64'($urandom_range(0, 5000000)));
      endcase
      send_walk($urandom_range(30, 70));
    end
  endtask

  task automatic test_noise(int n);
    for (int i = 0; i < n; i++) send_sample($urandom, $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_walk(20);
    wait (long_hold_done);
    long_hold_req = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    send_walk(10);
    stop_sending();
    wait (pending_results.size() == 0);
    send_walk(10);
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_walking(4);
    test_noise(40);
    test_backpressure();
    test_pause_until_empty();
    test_walking(3);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_walking(2);
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/asc_pkg.sv
rtl/asc_if.sv
rtl/asc_cfg_if.sv
rtl/asc_mac.sv
rtl/asc_front.sv
rtl/asc_queue.sv
rtl/asc_back.sv
rtl/accel_step_counter_top.sv
rtl/asc_checker.sv
tb/testbench.sv
